>>> hdl/rmds_pkg.sv
package rmds_pkg;

	localparam int CAPACITY = 1024;
	localparam int VALUE_W  = 32;
	localparam int DEV_W    = 43;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	// operation codes; code 3 acts as a query
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_ABSENT = 2'd1;
	localparam logic [1:0] ERR_FULL   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE_LO,
		ST_PRE_HI,
		ST_PRE_CAP,
		ST_SRCH_A,
		ST_SRCH_B,
		ST_RM_CHK,
		ST_RM_SH_R,
		ST_RM_SH_W,
		ST_INS_SH_R,
		ST_INS_SH_W,
		ST_INS_WR,
		ST_FIN_LO,
		ST_FIN_HI,
		ST_FIN_OUT
	} state_t;

	// read address source
	typedef enum logic [2:0] {
		RA_LO,
		RA_HI,
		RA_MID,
		RA_POS,
		RA_DN,
		RA_UP
	} rsel_t;

	typedef struct packed {
		logic       load;
		rsel_t      rsel;
		logic       cap_lo;
		logic       cap_hi;
		logic       bnd_init;
		logic       bnd_step;
		logic       ptr_ins;
		logic       ptr_rm;
		logic       ptr_inc;
		logic       ptr_dec;
		logic       wr_shift;
		logic       wr_x;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       set_ok;
		logic       set_err;
		logic [1:0] err_code;
		logic       dev_upd;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_ins;
		logic is_rm;
		logic empty;
		logic full;
		logic bnd_eq;
		logic pos_end;
		logic match;
		logic ins_sh_done;
		logic rm_sh_done;
	} sts_t;

endpackage

>>> hdl/rmds_ctrl.sv
module rmds_ctrl import rmds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rsel = RA_LO;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_PRE_LO;
				end
			end
			ST_PRE_LO: begin
				if (sts.is_ins && sts.full) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ERR_FULL;
					state_d      = ST_FIN_LO;
				end else if (sts.is_rm && sts.empty) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ERR_ABSENT;
					state_d      = ST_FIN_LO;
				end else if (!sts.is_ins && !sts.is_rm) begin
					state_d = ST_FIN_LO;
				end else begin
					cmd.rsel = RA_LO;
					state_d  = ST_PRE_HI;
				end
			end
			ST_PRE_HI: begin
				cmd.rsel   = RA_HI;
				cmd.cap_lo = 1'b1;
				state_d    = ST_PRE_CAP;
			end
			ST_PRE_CAP: begin
				cmd.cap_hi   = 1'b1;
				cmd.bnd_init = 1'b1;
				state_d      = ST_SRCH_A;
			end
			ST_SRCH_A: begin
				if (!sts.bnd_eq) begin
					cmd.rsel = RA_MID;
					state_d  = ST_SRCH_B;
				end else if (sts.is_ins) begin
					cmd.ptr_ins = 1'b1;
					state_d     = ST_INS_SH_R;
				end else if (sts.pos_end) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ERR_ABSENT;
					state_d      = ST_FIN_LO;
				end else begin
					cmd.rsel = RA_POS;
					state_d  = ST_RM_CHK;
				end
			end
			ST_SRCH_B: begin
				cmd.bnd_step = 1'b1;
				state_d      = ST_SRCH_A;
			end
			ST_RM_CHK: begin
				if (sts.match) begin
					cmd.ptr_rm = 1'b1;
					state_d    = ST_RM_SH_R;
				end else begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ERR_ABSENT;
					state_d      = ST_FIN_LO;
				end
			end
			ST_RM_SH_R: begin
				if (sts.rm_sh_done) begin
					cmd.cnt_dec = 1'b1;
					cmd.set_ok  = 1'b1;
					state_d     = ST_FIN_LO;
				end else begin
					cmd.rsel = RA_UP;
					state_d  = ST_RM_SH_W;
				end
			end
			ST_RM_SH_W: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_d      = ST_RM_SH_R;
			end
			ST_INS_SH_R: begin
				if (sts.ins_sh_done) begin
					state_d = ST_INS_WR;
				end else begin
					cmd.rsel = RA_DN;
					state_d  = ST_INS_SH_W;
				end
			end
			ST_INS_SH_W: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_dec  = 1'b1;
				state_d      = ST_INS_SH_R;
			end
			ST_INS_WR: begin
				cmd.wr_x    = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.set_ok  = 1'b1;
				state_d     = ST_FIN_LO;
			end
			ST_FIN_LO: begin
				cmd.rsel = RA_LO;
				state_d  = ST_FIN_HI;
			end
			ST_FIN_HI: begin
				cmd.rsel    = RA_HI;
				cmd.dev_upd = 1'b1;
				cmd.cap_lo  = 1'b1;
				state_d     = ST_FIN_OUT;
			end
			ST_FIN_OUT: begin
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/rmds_dp.sv
module rmds_dp import rmds_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [1:0]                operation,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      done,
	output logic signed [VALUE_W-1:0] lower_median,
	output logic signed [VALUE_W-1:0] mid_median,
	output logic [DEV_W-1:0]          deviation_sum,
	output logic [CNT_W-1:0]          element_count,
	output logic                      is_empty,
	output logic [1:0]                error
);

	logic [VALUE_W-1:0]        mem [CAPACITY];
	logic signed [VALUE_W-1:0] rdata_q;
	logic [ADDR_W-1:0]         raddr;
	logic [ADDR_W-1:0]         waddr;
	logic [VALUE_W-1:0]        wdata;
	logic                      wen;

	logic [1:0]                op_q;
	logic signed [VALUE_W-1:0] x_q;
	logic [CNT_W-1:0]          count_q;
	logic [DEV_W-1:0]          dev_q;
	logic signed [VALUE_W-1:0] lo_q;
	logic signed [VALUE_W-1:0] hi_q;
	logic [CNT_W-1:0]          lob_q;
	logic [CNT_W-1:0]          hib_q;
	logic [CNT_W-1:0]          ptr_q;
	logic                      nz_q;
	logic                      ok_q;
	logic [1:0]                err_q;
	logic                      done_q;

	logic [CNT_W:0]            bsum;
	logic [ADDR_W-1:0]         mid_idx;
	logic [CNT_W-1:0]          cnt_m1;
	logic                      go_right;
	logic [VALUE_W:0]          add_amt;
	logic [VALUE_W:0]          sub_amt;
	logic signed [VALUE_W-1:0] sub_ref;
	logic signed [VALUE_W:0]   med_sum;
	logic signed [VALUE_W:0]   med_adj;

	function automatic logic [VALUE_W:0] abs_diff(input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b);
		logic signed [VALUE_W:0] d;
		d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
		return d[VALUE_W] ? -d : d;
	endfunction

	// decode and compare
	assign bsum    = {1'b0, lob_q} + {1'b0, hib_q};
	assign mid_idx = bsum[ADDR_W:1];
	assign cnt_m1  = count_q - 1'b1;
	assign go_right = (op_q == OP_INSERT) ? (rdata_q <= x_q) : (rdata_q < x_q);

	assign sts.is_ins      = (op_q == OP_INSERT);
	assign sts.is_rm       = (op_q == OP_REMOVE);
	assign sts.empty       = (count_q == '0);
	assign sts.full        = (count_q == CNT_W'(CAPACITY));
	assign sts.bnd_eq      = (lob_q == hib_q);
	assign sts.pos_end     = (lob_q == count_q);
	assign sts.match       = (rdata_q == x_q);
	assign sts.ins_sh_done = (ptr_q == lob_q);
	assign sts.rm_sh_done  = (({1'b0, ptr_q} + 1'b1) >= {1'b0, count_q});

	// select read address
	always_comb begin
		unique case (cmd.rsel)
			RA_LO:   raddr = ADDR_W'(cnt_m1 >> 1);
			RA_HI:   raddr = ADDR_W'(count_q >> 1);
			RA_MID:  raddr = mid_idx;
			RA_POS:  raddr = ADDR_W'(lob_q);
			RA_DN:   raddr = ADDR_W'(ptr_q - 1'b1);
			RA_UP:   raddr = ADDR_W'(ptr_q + 1'b1);
			default: raddr = '0;
		endcase
	end

	// select write port
	assign wen   = cmd.wr_shift | cmd.wr_x;
	assign waddr = cmd.wr_x ? ADDR_W'(lob_q) : ADDR_W'(ptr_q);
	assign wdata = cmd.wr_x ? x_q : rdata_q;

	// sorted store
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// deviation correction terms
	always_comb begin
		if (x_q < lo_q) begin
			add_amt = abs_diff(lo_q, x_q);
		end else if (x_q > hi_q) begin
			add_amt = abs_diff(x_q, hi_q);
		end else begin
			add_amt = '0;
		end
		sub_ref = count_q[0] ? rdata_q : lo_q;
		sub_amt = abs_diff(sub_ref, x_q);
	end

	// midpoint, truncated toward zero
	assign med_sum = {lo_q[VALUE_W-1], lo_q} + {rdata_q[VALUE_W-1], rdata_q};
	assign med_adj = med_sum + {{VALUE_W{1'b0}}, med_sum[VALUE_W]};

	// control state: count, deviation, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dev_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.out_load;
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.dev_upd && ok_q) begin
				if (op_q == OP_INSERT && nz_q) begin
					dev_q <= dev_q + DEV_W'(add_amt);
				end else if (op_q == OP_REMOVE) begin
					dev_q <= dev_q - DEV_W'(sub_amt);
				end
			end
		end
	end

	// transaction working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			x_q   <= value;
			nz_q  <= (count_q != '0);
			ok_q  <= 1'b0;
			err_q <= ERR_NONE;
		end
		if (cmd.set_ok) begin
			ok_q <= 1'b1;
		end
		if (cmd.set_err) begin
			err_q <= cmd.err_code;
		end
		if (cmd.cap_lo) begin
			lo_q <= rdata_q;
		end
		if (cmd.cap_hi) begin
			hi_q <= rdata_q;
		end
		if (cmd.bnd_init) begin
			lob_q <= '0;
			hib_q <= count_q;
		end else if (cmd.bnd_step) begin
			if (go_right) begin
				lob_q <= CNT_W'(mid_idx) + 1'b1;
			end else begin
				hib_q <= CNT_W'(mid_idx);
			end
		end
		if (cmd.ptr_ins) begin
			ptr_q <= count_q;
		end else if (cmd.ptr_rm) begin
			ptr_q <= lob_q;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + 1'b1;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (count_q == '0) begin
				lower_median  <= '0;
				mid_median    <= '0;
				deviation_sum <= '0;
			end else begin
				lower_median  <= lo_q;
				mid_median    <= med_adj[VALUE_W:1];
				deviation_sum <= dev_q;
			end
			element_count <= count_q;
			is_empty      <= (count_q == '0);
			error         <= err_q;
		end
	end

	assign done = done_q;

endmodule

>>> hdl/running_median_deviation_sum.sv
// Sequence: a query steps through PRE_LO, FIN_LO, FIN_HI and FIN_OUT to the done strobe; an insert
// or removal also captures the medians, runs a binary search over the n values held and shifts the
// m values moved through the sorted store, with a read state and a write state for each value.
// One transaction at a time: busy stays high until the result strobe.
// Each result is flagged by done for one cycle and held until the next; the receiver cannot stall.
// Reset clears the count, the deviation total and the controller; the store is not cleared.
module running_median_deviation_sum import rmds_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      done,
	output logic signed [VALUE_W-1:0] lower_median,
	output logic signed [VALUE_W-1:0] mid_median,
	output logic [DEV_W-1:0]          deviation_sum,
	output logic [CNT_W-1:0]          element_count,
	output logic                      is_empty,
	output logic [1:0]                error
);

	cmd_t cmd;
	sts_t sts;

	// sequence each transaction
	rmds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// store, search, shift and result math
	rmds_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.value         (value),
		.done          (done),
		.lower_median  (lower_median),
		.mid_median    (mid_median),
		.deviation_sum (deviation_sum),
		.element_count (element_count),
		.is_empty      (is_empty),
		.error         (error)
	);

endmodule
